/* rtl/core/assert_macros.svh */
// Assertion macros for the checker of the rational arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RAU_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rau_pkg.sv */
// Types and constants of the rational arithmetic unit.
package rau_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_EQ  = 3'd4;
    localparam logic [2:0] OP_RED = 3'd5;
    localparam logic [2:0] OP_GCD = 3'd6;
    localparam logic [2:0] OP_LCM = 3'd7;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZERO = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } rau_in_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic               is_equal;
        logic [1:0]         error_code;
    } rau_out_t;

    typedef enum logic [1:0] {MS_AN_BD, MS_BN_AD, MS_AD_BD, MS_AN_BN} mul_sel_t;
    typedef enum logic [1:0] {MD_P, MD_Q, MD_RN, MD_RD} mul_dst_t;
    typedef enum logic [1:0] {DS_EU, DS_AN, DS_AD, DS_P} div_src_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        mul_dst_t mul_dst;
        logic     addsub;
        logic     sub;
        logic     cmp;
        logic     eu_init;
        logic     eu_den;
        logic     div_start;
        div_src_t div_src;
        logic     rn_from_x;
        logic     rd_one;
        logic     finish;
    } rau_cmd_t;

    typedef struct packed {
        logic err_zero;
        logic div_done;
        logic y_zero;
    } rau_sts_t;

endpackage

/* rtl/core/rau_div.sv */
// Iterative restoring divider with truncating signed quotient and remainder.
module rau_div
    import rau_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] dividend,
    input  logic signed [31:0] divisor,
    output logic               done,
    output logic signed [63:0] quotient,
    output logic signed [31:0] remainder
);
    localparam int STEPS = 64;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      acc_reg, acc_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      dsr_reg;
    logic             qneg_reg, rneg_reg;
    logic [32:0]      shifted, diff;
    logic             fits;

    always_comb begin
        shifted  = {rem_reg, acc_reg[63]};
        diff     = shifted - {1'b0, dsr_reg};
        fits     = shifted >= {1'b0, dsr_reg};
        rem_next = fits ? diff[31:0] : shifted[31:0];
        acc_next = {acc_reg[62:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
            dsr_reg  <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            rem_reg  <= '0;
            qneg_reg <= dividend[63] ^ divisor[31];
            rneg_reg <= dividend[63];
        end else if (busy_reg) begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? -$signed(acc_reg) : $signed(acc_reg);
    assign remainder = rneg_reg ? -$signed(rem_reg) : $signed(rem_reg);

endmodule

/* rtl/core/rau_dp.sv */
// Datapath: operand registers, shared multiplier, Euclid registers and divider.
module rau_dp
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  rau_in_t  s_data,
    input  rau_cmd_t cmd,
    output rau_sts_t sts,
    output rau_out_t m_data
);
    logic signed [DATA_WIDTH-1:0] an_lo, ad_lo, bn_lo, bd_lo;
    logic signed [31:0] an_sx, ad_sx, bn_sx, bd_sx;
    logic signed [31:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [31:0] x_reg, y_reg;
    logic signed [63:0] p_reg, q_reg, rn_reg, rd_reg;
    logic               eq_reg;
    logic [1:0]         err_reg, err_load;
    div_src_t           src_reg;
    rau_out_t           out_reg;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] product;
    logic signed [64:0] sum;
    logic signed [63:0] div_dvd;
    logic               div_done;
    logic signed [63:0] div_q;
    logic signed [31:0] div_r;

    assign an_lo = s_data.a_num[DATA_WIDTH-1:0];
    assign ad_lo = s_data.a_den[DATA_WIDTH-1:0];
    assign bn_lo = s_data.b_num[DATA_WIDTH-1:0];
    assign bd_lo = s_data.b_den[DATA_WIDTH-1:0];
    assign an_sx = 32'(an_lo);
    assign ad_sx = 32'(ad_lo);
    assign bn_sx = 32'(bn_lo);
    assign bd_sx = 32'(bd_lo);

    always_comb begin
        err_load = ERR_OK;
        unique case (s_data.opcode)
            OP_ADD, OP_SUB, OP_MUL, OP_EQ: begin
                if (ad_sx == 0 || bd_sx == 0) err_load = ERR_ZERO;
            end
            OP_DIV: begin
                if (ad_sx == 0 || bd_sx == 0 || bn_sx == 0) err_load = ERR_ZERO;
            end
            OP_RED: begin
                if (ad_sx == 0) err_load = ERR_ZERO;
            end
            default: begin
                if (bn_sx == 0) err_load = ERR_ZERO;
            end
        endcase
    end

    always_comb begin
        unique case (cmd.mul_sel)
            MS_AN_BD: begin mul_a = an_reg; mul_b = bd_reg; end
            MS_BN_AD: begin mul_a = bn_reg; mul_b = ad_reg; end
            MS_AD_BD: begin mul_a = ad_reg; mul_b = bd_reg; end
            default:  begin mul_a = an_reg; mul_b = bn_reg; end
        endcase
        product = mul_a * mul_b;
        sum = cmd.sub ? (65'(p_reg) - 65'(q_reg)) : (65'(p_reg) + 65'(q_reg));
        unique case (cmd.div_src)
            DS_EU:   div_dvd = 64'(x_reg);
            DS_AN:   div_dvd = 64'(an_reg);
            DS_AD:   div_dvd = 64'(ad_reg);
            default: div_dvd = p_reg;
        endcase
    end

    rau_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (cmd.div_src == DS_EU ? y_reg : x_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            an_reg  <= an_sx;
            ad_reg  <= ad_sx;
            bn_reg  <= bn_sx;
            bd_reg  <= bd_sx;
            err_reg <= err_load;
            eq_reg  <= 1'b0;
        end
        if (cmd.mul_en) begin
            unique case (cmd.mul_dst)
                MD_P:    p_reg  <= product;
                MD_Q:    q_reg  <= product;
                MD_RN:   rn_reg <= product;
                default: rd_reg <= product;
            endcase
        end
        if (cmd.addsub) begin
            rn_reg <= sum[63:0];
            if (sum[64] != sum[63]) err_reg <= ERR_OVF;
        end
        if (cmd.cmp) begin
            eq_reg <= (p_reg == q_reg);
            rn_reg <= '0;
            rd_reg <= 64'sd1;
        end
        if (cmd.eu_init) begin
            x_reg <= an_reg;
            y_reg <= cmd.eu_den ? ad_reg : bn_reg;
        end
        if (cmd.div_start) src_reg <= cmd.div_src;
        if (div_done) begin
            unique case (src_reg)
                DS_EU: begin
                    x_reg <= y_reg;
                    y_reg <= div_r;
                end
                DS_AD:   rd_reg <= div_q;
                default: rn_reg <= div_q;
            endcase
        end
        if (cmd.rn_from_x) rn_reg <= 64'(x_reg);
        if (cmd.rd_one)    rd_reg <= 64'sd1;
        if (cmd.finish) begin
            if (err_reg != ERR_OK) begin
                out_reg.res_num  <= '0;
                out_reg.res_den  <= '0;
                out_reg.is_equal <= 1'b0;
            end else begin
                out_reg.res_num  <= rn_reg;
                out_reg.res_den  <= rd_reg;
                out_reg.is_equal <= eq_reg;
            end
            out_reg.error_code <= err_reg;
        end
    end

    assign sts.err_zero = (err_reg == ERR_ZERO);
    assign sts.div_done = div_done;
    assign sts.y_zero   = (y_reg == 0);
    assign m_data       = out_reg;

endmodule

/* rtl/core/rau_ctrl.sv */
// Controller: sequences the datapath for each opcode and owns both handshakes.
module rau_ctrl
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic [2:0] s_opcode,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  rau_sts_t sts,
    output rau_cmd_t cmd
);
    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_MUL_A, S_MUL_B, S_ADDSUB, S_MUL_C, S_CMP,
        S_EU_INIT, S_EU_START, S_EU_WAIT, S_EU_TEST, S_GCD,
        S_DV1_START, S_DV1_WAIT, S_DV2_START, S_DV2_WAIT, S_FIN
    } state_t;

    state_t     state_reg;
    logic [2:0] op_reg;
    logic       m_valid_reg;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = MS_AN_BD;
        cmd.mul_dst = MD_P;
        cmd.div_src = DS_EU;
        cmd.sub     = (op_reg == OP_SUB);
        unique case (state_reg)
            S_IDLE: cmd.load = s_valid;
            S_MUL_A: begin
                cmd.mul_en = 1'b1;
                priority if (op_reg == OP_MUL) begin
                    cmd.mul_sel = MS_AN_BN;
                    cmd.mul_dst = MD_RN;
                end else if (op_reg == OP_DIV) begin
                    cmd.mul_dst = MD_RN;
                end else if (op_reg == OP_LCM) begin
                    cmd.mul_sel = MS_AN_BN;
                end else begin
                    // Add, subtract and equal form a_num * b_den into p.
                    cmd.mul_sel = MS_AN_BD;
                end
            end
            S_MUL_B: begin
                cmd.mul_en = 1'b1;
                priority if (op_reg == OP_MUL) begin
                    cmd.mul_sel = MS_AD_BD;
                    cmd.mul_dst = MD_RD;
                end else if (op_reg == OP_DIV) begin
                    cmd.mul_sel = MS_BN_AD;
                    cmd.mul_dst = MD_RD;
                end else begin
                    cmd.mul_sel = MS_BN_AD;
                    cmd.mul_dst = MD_Q;
                end
            end
            S_ADDSUB: cmd.addsub = 1'b1;
            S_MUL_C: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_AD_BD;
                cmd.mul_dst = MD_RD;
            end
            S_CMP: cmd.cmp = 1'b1;
            S_EU_INIT: begin
                cmd.eu_init = 1'b1;
                cmd.eu_den  = (op_reg == OP_RED);
            end
            S_EU_START: cmd.div_start = 1'b1;
            S_GCD: begin
                cmd.rn_from_x = 1'b1;
                cmd.rd_one    = 1'b1;
            end
            S_DV1_START: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = (op_reg == OP_RED) ? DS_AN : DS_P;
                cmd.rd_one    = (op_reg == OP_LCM);
            end
            S_DV1_WAIT: cmd.div_src = (op_reg == OP_RED) ? DS_AN : DS_P;
            S_DV2_START: begin
                cmd.div_start = 1'b1;
                cmd.div_src   = DS_AD;
            end
            S_DV2_WAIT: cmd.div_src = DS_AD;
            S_FIN: cmd.finish = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            op_reg      <= OP_ADD;
            m_valid_reg <= 1'b0;
        end else begin
            // A new result takes precedence over the one being consumed this cycle.
            if (state_reg == S_FIN && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= s_opcode;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    priority if (sts.err_zero) begin
                        state_reg <= S_FIN;
                    end else if (op_reg == OP_RED || op_reg == OP_GCD
                                 || op_reg == OP_LCM) begin
                        state_reg <= S_EU_INIT;
                    end else begin
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A: state_reg <= (op_reg == OP_LCM) ? S_DV1_START : S_MUL_B;
                S_MUL_B: begin
                    priority if (op_reg == OP_ADD || op_reg == OP_SUB) begin
                        state_reg <= S_ADDSUB;
                    end else if (op_reg == OP_EQ) begin
                        state_reg <= S_CMP;
                    end else begin
                        state_reg <= S_FIN;
                    end
                end
                S_ADDSUB:   state_reg <= S_MUL_C;
                S_MUL_C:    state_reg <= S_FIN;
                S_CMP:      state_reg <= S_FIN;
                S_EU_INIT:  state_reg <= S_EU_START;
                S_EU_START: state_reg <= S_EU_WAIT;
                S_EU_WAIT:  if (sts.div_done) state_reg <= S_EU_TEST;
                S_EU_TEST: begin
                    priority if (!sts.y_zero) begin
                        state_reg <= S_EU_START;
                    end else if (op_reg == OP_GCD) begin
                        state_reg <= S_GCD;
                    end else if (op_reg == OP_RED) begin
                        state_reg <= S_DV1_START;
                    end else begin
                        state_reg <= S_MUL_A;
                    end
                end
                S_GCD:       state_reg <= S_FIN;
                S_DV1_START: state_reg <= S_DV1_WAIT;
                S_DV1_WAIT: begin
                    if (sts.div_done) begin
                        state_reg <= (op_reg == OP_RED) ? S_DV2_START : S_FIN;
                    end
                end
                S_DV2_START: state_reg <= S_DV2_WAIT;
                S_DV2_WAIT:  if (sts.div_done) state_reg <= S_FIN;
                S_FIN: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Top level of the rational arithmetic unit: controller, datapath and handshake ports.
//
//   Channel | Ports                     | Moves per transaction
//   --------+---------------------------+------------------------------------------
//   s_      | s_valid s_ready s_data    | opcode and two signed fractions
//   m_      | m_valid m_ready m_data    | numerator, denominator, equality, error
//
// After the check, multiply and divide form two products in turn, equal then compares,
// and add and subtract form the sum and a third product, on the single shared 32 by 32
// multiplier used once per cycle; a zero denominator or divisor skips to finish.
// Reduce, gcd and lcm run Euclid's loop on a 64-step restoring divider; reduce then
// divides twice more, and lcm multiplies once and divides once more.
// One transaction is in flight at a time; a finished result waits in the output
// register, and the next transaction is taken while it waits. Reset is synchronous and
// active low, and clears only the control state.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rau_out_t m_data
);
    // Command and status bundles between the sequencer and the datapath.
    rau_cmd_t cmd;
    rau_sts_t sts;

    // The controller owns both handshakes and walks each opcode's schedule.
    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_data.opcode),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath takes the low DATA_WIDTH bits of each operand, sign-extended.
    rau_dp #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

/* rtl/core/rau_checker.sv */
// Port-level checker for the rational arithmetic unit, bound to the top level.
`include "assert_macros.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input rau_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input rau_out_t m_data
);
    `RAU_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `RAU_ASSERT_NOW(a_err_zeroes, aclk, aresetn, m_valid && m_data.error_code != ERR_OK, m_data.res_num == 0 && m_data.res_den == 0 && !m_data.is_equal, "error result not cleared")
    `RAU_ASSERT_NOW(a_eq_form, aclk, aresetn, m_valid && m_data.is_equal, m_data.error_code == ERR_OK && m_data.res_num == 0 && m_data.res_den == 1, "equal result malformed")
    `RAU_ASSERT_NOW(a_err_code, aclk, aresetn, m_valid, m_data.error_code != 2'd3, "undefined error code")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

/* test/tb_top.sv */
// Self-checking testbench for the rational arithmetic unit: burst driver and checking monitor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    localparam int DATA_WIDTH     = 32;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int MAX_MISMATCH   = 10;
    localparam int SETTLE_CYCLES  = 400;
    localparam int LONG_HOLD      = 3000;
    localparam int HOLD_AT_ITEM   = 400;
    // The cycle limit leaves a wide margin for Euclid's loop on full-width operands.
    localparam longint CYCLE_LIMIT = 40_000_000;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    rau_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    rau_out_t m_data;

    rau_in_t  pending_items[$];
    rau_out_t expected_results[$];

    int     mismatches   = 0;
    int     items_sent   = 0;
    int     results_seen = 0;
    bit     stimulus_done;
    longint cycle_count  = 0;

    rational_arithmetic_unit #(.DATA_WIDTH(DATA_WIDTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Euclid's algorithm with a truncating remainder; the sign of the result
    // follows from the operands, so a negative gcd is expected behaviour.
    function automatic longint euclid_gcd(longint x, longint y);
        longint r;
        do begin
            r = x % y;
            x = y;
            y = r;
        end while (r != 0);
        return x;
    endfunction

    // Works out the single result that one input transaction should produce.
    // Only the low DATA_WIDTH bits of each operand count, sign-extended.
    function automatic rau_out_t predict_rational(rau_in_t t);
        rau_out_t   res;
        longint     an, ad, bn, bd, p, q, g;
        logic [64:0] wide;
        an = longint'($signed(t.a_num[DATA_WIDTH-1:0]));
        ad = longint'($signed(t.a_den[DATA_WIDTH-1:0]));
        bn = longint'($signed(t.b_num[DATA_WIDTH-1:0]));
        bd = longint'($signed(t.b_den[DATA_WIDTH-1:0]));
        res = '0;
        res.error_code = ERR_OK;
        case (t.opcode)
            OP_ADD, OP_SUB: begin
                if (ad == 0 || bd == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    p = an * bd;
                    q = bn * ad;
                    // A 65-bit sum shows overflow as a disagreement of the top two bits.
                    if (t.opcode == OP_ADD)
                        wide = {p[63], p} + {q[63], q};
                    else
                        wide = {p[63], p} - {q[63], q};
                    if (wide[64] != wide[63]) begin
                        res.error_code = ERR_OVF;
                    end else begin
                        res.res_num = wide[63:0];
                        res.res_den = ad * bd;
                    end
                end
            end
            OP_MUL: begin
                if (ad == 0 || bd == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    res.res_num = an * bn;
                    res.res_den = ad * bd;
                end
            end
            OP_DIV: begin
                if (ad == 0 || bd == 0 || bn == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    res.res_num = an * bd;
                    res.res_den = ad * bn;
                end
            end
            OP_EQ: begin
                if (ad == 0 || bd == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    res.is_equal = (an * bd == bn * ad);
                    res.res_num  = 0;
                    res.res_den  = 1;
                end
            end
            OP_RED: begin
                if (ad == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    g = euclid_gcd(an, ad);
                    res.res_num = an / g;
                    res.res_den = ad / g;
                end
            end
            OP_GCD: begin
                if (bn == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    res.res_num = euclid_gcd(an, bn);
                    res.res_den = 1;
                end
            end
            default: begin
                if (bn == 0) begin
                    res.error_code = ERR_ZERO;
                end else begin
                    g = euclid_gcd(an, bn);
                    res.res_num = (an * bn) / g;
                    res.res_den = 1;
                end
            end
        endcase
        // Every error clears the value fields.
        if (res.error_code != ERR_OK) begin
            res.res_num  = 0;
            res.res_den  = 0;
            res.is_equal = 1'b0;
        end
        return res;
    endfunction

    // Operand values biased towards zero, the extremes and small magnitudes,
    // with full-width values often enough that every bit toggles.
    function automatic logic signed [31:0] random_operand();
        case ($urandom_range(0, 9))
            0: return 32'sd0;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            2, 3, 4, 5: return 32'($signed($urandom_range(0, 200)) - 100);
            6, 7: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic rau_in_t make_item(logic [2:0] op, int an, int ad, int bn, int bd);
        rau_in_t t;
        t.opcode = op;
        t.a_num  = an;
        t.a_den  = ad;
        t.b_num  = bn;
        t.b_den  = bd;
        return t;
    endfunction

    // Stimulus: a directed set first, then random transactions.
    initial begin
        rau_in_t t;
        localparam int IMIN = 32'sh8000_0000;
        localparam int IMAX = 32'sh7fff_ffff;
        stimulus_done = 1'b0;
        pending_items.push_back(make_item(OP_ADD, 1, 2, 1, 3));
        pending_items.push_back(make_item(OP_SUB, 1, 2, 1, 3));
        pending_items.push_back(make_item(OP_MUL, -3, 4, 5, -7));
        pending_items.push_back(make_item(OP_DIV, 3, 4, 5, 7));
        pending_items.push_back(make_item(OP_EQ, 1, 2, 2, 4));
        pending_items.push_back(make_item(OP_EQ, 1, 2, 2, 5));
        pending_items.push_back(make_item(OP_RED, 12, -18, 0, 0));
        pending_items.push_back(make_item(OP_GCD, -12, 18, 0, 0));
        pending_items.push_back(make_item(OP_LCM, 4, 6, 6, 0));
        // Zero operand denominators, a zero divisor and zero gcd and lcm divisors.
        pending_items.push_back(make_item(OP_ADD, 1, 0, 1, 1));
        pending_items.push_back(make_item(OP_EQ, 1, 1, 1, 0));
        pending_items.push_back(make_item(OP_RED, 5, 0, 1, 1));
        pending_items.push_back(make_item(OP_DIV, 1, 2, 0, 3));
        pending_items.push_back(make_item(OP_GCD, 7, 1, 0, 1));
        pending_items.push_back(make_item(OP_LCM, 7, 1, 0, 1));
        // Extreme operands on the widest cross products; the first addition overflows.
        pending_items.push_back(make_item(OP_ADD, IMIN, IMIN, IMIN, IMIN));
        pending_items.push_back(make_item(OP_SUB, IMIN, IMIN, IMAX, IMIN));
        pending_items.push_back(make_item(OP_SUB, IMAX, IMAX, IMIN, IMAX));
        pending_items.push_back(make_item(OP_MUL, IMIN, IMIN, IMIN, IMIN));
        pending_items.push_back(make_item(OP_RED, IMIN, -1, 0, 0));
        pending_items.push_back(make_item(OP_RED, 0, -5, 0, 0));
        pending_items.push_back(make_item(OP_LCM, IMIN, 1, IMAX, 1));
        pending_items.push_back(make_item(OP_GCD, IMAX, 1, IMIN, 1));
        pending_items.push_back(make_item(OP_DIV, IMAX, IMIN, IMIN, IMAX));
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            t.opcode = 3'($urandom_range(0, 7));
            t.a_num  = random_operand();
            t.a_den  = random_operand();
            t.b_num  = random_operand();
            t.b_den  = random_operand();
            pending_items.push_back(t);
        end
        stimulus_done = 1'b1;
    end

    // Reset is asserted at the start and never asserted again.
    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Driver: bursts of random length separated by random gaps. Valid stays high
    // with a steady payload until the transaction is accepted.
    int burst_left;
    int gap_left;

    always @(posedge aclk) begin
        logic    next_valid;
        rau_in_t next_data;
        next_valid = s_valid;
        next_data  = s_data;
        if (!aresetn) begin
            next_valid = 1'b0;
            next_data  = '0;
            burst_left = $urandom_range(1, 20);
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_rational(pending_items.pop_front()));
                items_sent++;
                next_valid = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    // Occasionally no gap at all, otherwise a gap of random length.
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    burst_left = $urandom_range(1, 20);
                end
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    next_valid = 1'b1;
                    next_data  = pending_items[0];
                end
            end
        end
        s_valid <= next_valid;
        s_data  <= next_data;
    end

    // Receiver stall pattern, with one long hold-off while the sender keeps
    // offering so that the unit fills up and drops s_ready.
    int  hold_left;
    bit  hold_done;
    int  stall_mode;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            hold_left  = 0;
            hold_done  = 1'b0;
            stall_mode = 0;
        end else begin
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if ($urandom_range(0, 255) == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 1) == 1);
                    default: m_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        rau_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_MISMATCH)
                    $display("Unexpected result transaction: num %0d den %0d eq %0b err %0d",
                             m_data.res_num, m_data.res_den, m_data.is_equal,
                             m_data.error_code);
            end else begin
                want = expected_results.pop_front();
                if (m_data.res_num !== want.res_num || m_data.res_den !== want.res_den ||
                    m_data.is_equal !== want.is_equal ||
                    m_data.error_code !== want.error_code) begin
                    mismatches++;
                    if (mismatches <= MAX_MISMATCH)
                        $display("Mismatch on result %0d:", results_seen,
                                 " expected num %0d den %0d eq %0b err %0d,",
                                 want.res_num, want.res_den, want.is_equal,
                                 want.error_code,
                                 " got num %0d den %0d eq %0b err %0d",
                                 m_data.res_num, m_data.res_den,
                                 m_data.is_equal, m_data.error_code);
                end
            end
        end
    end

    // Cycle limit in case the unit hangs.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // End of run: all transactions sent and all results back, then a settling pause
    // to catch any stray result.
    initial begin
        wait (stimulus_done);
        wait (aresetn);
        do begin
            @(posedge aclk);
        end while (pending_items.size() > 0 || expected_results.size() > 0 || s_valid);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
